/* hdl/epoch_seconds_ordinal_date_convert_core_defines.svh */
// Assertion macros for the epoch seconds / ordinal date converter.
`ifndef EPOCH_SECONDS_ORDINAL_DATE_CONVERT_CORE_DEFINES_SVH
`define EPOCH_SECONDS_ORDINAL_DATE_CONVERT_CORE_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define ESOD_ASSERT_IMPLY(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("esod: same-cycle check failed");

// Next-cycle implication.
`define ESOD_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("esod: next-cycle check failed");

`endif

/* hdl/esod_pkg.sv */
// Types and constants shared by the epoch seconds / ordinal date converter.
package esod_pkg;

  typedef struct packed {
    logic        opcode;
    logic [30:0] utc_seconds;
    logic [15:0] packed_date_in;
    logic [10:0] minutes_left_in;
    logic [5:0]  seconds_left_in;
  } in_req_t;

  typedef struct packed {
    logic [15:0] packed_date_out;
    logic [10:0] minutes_left_out;
    logic [5:0]  seconds_left_out;
    logic [9:0]  tick_count;
    logic [30:0] local_seconds;
    logic        range_error;
  } out_rsp_t;

  localparam int CfgWidth    = 17;
  localparam int CfgIdxWidth = 1;

  localparam logic [CfgIdxWidth-1:0] REG_ZONE_OFFSET      = 1'd0;
  localparam logic [CfgIdxWidth-1:0] REG_TICKS_PER_SECOND = 1'd1;

  localparam logic OP_TO_DATE    = 1'b0;
  localparam logic OP_TO_SECONDS = 1'b1;

  localparam logic [1:0] DIV_DAY  = 2'd0;
  localparam logic [1:0] DIV_MIN  = 2'd1;
  localparam logic [1:0] DIV_YEAR = 2'd2;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;
  localparam logic [16:0] YEAR_SCALE    = 17'd1000;
  localparam logic [10:0] MINS_PER_DAY  = 11'd1440;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [8:0]  DAYS_PER_LEAP = 9'd366;

  // quotient step, then remainder step
  localparam logic [1:0] DIV_STEPS = 2'd2;

  // rounded-up reciprocals: day split is (x >> 7) / 675 with a 35-bit shift,
  // minutes split is x / 60 with a 23-bit shift, year split is x / 1000 with 26
  localparam logic [25:0] RECIP_DAY  = 26'd50903317;
  localparam logic [25:0] RECIP_MIN  = 26'd139811;
  localparam logic [25:0] RECIP_YEAR = 26'd67109;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic [1:0] div_sel;
    logic       div_step;
    logic       split;
    logic       year_step;
    logic       prod_a;
    logic       prod_b;
    logic       sum;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic opcode;
    logic neg;
    logic zero;
    logic div_done;
    logic year_hit;
    logic slot_free;
  } sts_t;

endpackage

/* hdl/esod_ctrl.sv */
// Sequencer for the converter: accepts a request and steps the datapath.
module esod_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  esod_pkg::sts_t sts,
  output esod_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_YEAR  = 3'd3;
  localparam logic [2:0] S_PROD  = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] phase, phase_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= esod_pkg::DIV_DAY;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.opcode == esod_pkg::OP_TO_DATE) begin
          if (sts.neg) begin
            state_next = S_DONE;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = esod_pkg::DIV_DAY;
            phase_next    = esod_pkg::DIV_DAY;
            state_next    = S_DIV;
          end
        end else begin
          if (sts.zero) begin
            state_next = S_DONE;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = esod_pkg::DIV_YEAR;
            phase_next    = esod_pkg::DIV_YEAR;
            state_next    = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (!sts.div_done) begin
          cmd.div_step = 1'b1;
        end else begin
          unique case (phase)
            esod_pkg::DIV_DAY: begin
              cmd.split  = 1'b1;
              state_next = S_YEAR;
            end
            esod_pkg::DIV_MIN: begin
              state_next = S_DONE;
            end
            esod_pkg::DIV_YEAR: begin
              cmd.prod_a = 1'b1;
              state_next = S_PROD;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_YEAR: begin
        if (sts.year_hit) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = esod_pkg::DIV_MIN;
          phase_next    = esod_pkg::DIV_MIN;
          state_next    = S_DIV;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      S_PROD: begin
        cmd.prod_b = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/esod_dpath.sv */
// Datapath: reciprocal-multiply divider, year stepper, date-to-seconds math, result register.
module esod_dpath (
  input  logic                  clk,
  input  logic                  rst,
  input  esod_pkg::in_req_t     in_data,
  input  logic signed [16:0]    zone_offset,
  input  logic [9:0]            ticks_per_second,
  input  esod_pkg::cmd_t        cmd,
  output esod_pkg::sts_t        sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output esod_pkg::out_rsp_t    out_data
);

  logic               op;
  logic signed [32:0] loc;
  logic [15:0]        date;
  logic               zero;
  logic [10:0]        mins_in;
  logic [5:0]         secs_in;

  logic [31:0] dvd;
  logic [16:0] rem;
  logic [14:0] quo;
  logic [16:0] dsor;
  logic [1:0]  dsel;
  logic [1:0]  dcnt;

  logic [14:0] days;
  logic [16:0] sod;
  logic [6:0]  year;

  logic [14:0]        cday;
  logic signed [18:0] clk_s;
  logic [31:0]        prod;
  logic signed [33:0] total;

  logic [24:0] mul_a;
  logic [25:0] mul_b;
  logic [49:0] mul_p;
  logic [14:0] qest;
  logic [31:0] qback;
  logic [8:0]  ylen;
  logic [17:0] pk;
  logic        pk_ovf;
  logic [6:0]  yq;
  logic [15:0] yq365;
  logic [6:0]  yq1;
  logic signed [18:0] mterm;
  logic        err0, err1;
  esod_pkg::out_rsp_t res;

  always_comb begin
    case (dsel)
      esod_pkg::DIV_MIN: begin
        mul_a = 25'(dvd[16:0]);
        mul_b = esod_pkg::RECIP_MIN;
      end
      esod_pkg::DIV_YEAR: begin
        mul_a = 25'(dvd[15:0]);
        mul_b = esod_pkg::RECIP_YEAR;
      end
      default: begin
        mul_a = dvd[31:7];
        mul_b = esod_pkg::RECIP_DAY;
      end
    endcase
  end

  assign mul_p = 50'(mul_a) * 50'(mul_b);

  always_comb begin
    case (dsel)
      esod_pkg::DIV_MIN:  qest = 15'(mul_p[33:23]);
      esod_pkg::DIV_YEAR: qest = 15'(mul_p[32:26]);
      default:            qest = mul_p[49:35];
    endcase
  end

  assign qback = 32'(quo) * 32'(dsor);
  assign ylen  = (year[1:0] == 2'd2) ? esod_pkg::DAYS_PER_LEAP : esod_pkg::DAYS_PER_YEAR;

  assign yq    = quo[6:0];
  assign yq365 = 16'(yq) * 16'(esod_pkg::DAYS_PER_YEAR);
  assign yq1   = yq + 7'd1;
  assign mterm = $signed(19'(esod_pkg::MINS_PER_DAY)) - $signed({8'd0, mins_in});

  assign pk     = 18'(year) * 18'(esod_pkg::YEAR_SCALE) + 18'(days) + 18'd1;
  assign pk_ovf = (pk[17:16] != 2'd0);
  assign err0   = loc[32] || pk_ovf;
  assign err1   = zero || total[33] || (total[32:31] != 2'd0);

  assign sts.opcode    = op;
  assign sts.neg       = loc[32];
  assign sts.zero      = zero;
  assign sts.div_done  = (dcnt == 2'd0);
  assign sts.year_hit  = (days < 15'(ylen));
  assign sts.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= in_data.opcode;
      loc     <= $signed({2'b00, in_data.utc_seconds})
               + $signed({{16{zone_offset[16]}}, zone_offset});
      date    <= in_data.packed_date_in - 16'd1;
      zero    <= (in_data.packed_date_in == 16'd0);
      mins_in <= in_data.minutes_left_in;
      secs_in <= in_data.seconds_left_in;
    end
    if (cmd.div_start) begin
      dsel <= cmd.div_sel;
      dcnt <= esod_pkg::DIV_STEPS;
      case (cmd.div_sel)
        esod_pkg::DIV_MIN: begin
          dvd  <= 32'(sod);
          dsor <= esod_pkg::SECS_PER_MIN;
        end
        esod_pkg::DIV_YEAR: begin
          dvd  <= 32'(date);
          dsor <= esod_pkg::YEAR_SCALE;
        end
        default: begin
          dvd  <= loc[31:0];
          dsor <= esod_pkg::SECS_PER_DAY;
        end
      endcase
    end else if (cmd.div_step) begin
      if (dcnt == esod_pkg::DIV_STEPS) begin
        quo <= qest;
      end else begin
        rem <= 17'(dvd - qback);
      end
      dcnt <= dcnt - 2'd1;
    end
    if (cmd.split) begin
      days <= quo;
      sod  <= rem;
      year <= '0;
    end else if (cmd.year_step) begin
      days <= days - 15'(ylen);
      year <= year + 7'd1;
    end
    if (cmd.prod_a) begin
      cday  <= 15'(rem[9:0]) + yq365[14:0] + 15'(yq1[6:2]);
      clk_s <= mterm * 19'sd60 + (19'sd60 - $signed({13'd0, secs_in}));
    end
    if (cmd.prod_b) begin
      prod <= 32'(cday) * 32'(esod_pkg::SECS_PER_DAY);
    end
    if (cmd.sum) begin
      total <= $signed({2'b00, prod}) + $signed({{15{clk_s[18]}}, clk_s});
    end
    if (cmd.emit) begin
      out_data <= res;
    end
  end

  always_comb begin
    res            = '0;
    res.tick_count = ticks_per_second;
    if (op == esod_pkg::OP_TO_DATE) begin
      res.range_error = err0;
      if (!err0) begin
        res.packed_date_out  = pk[15:0];
        res.minutes_left_out = esod_pkg::MINS_PER_DAY - quo[10:0];
        res.seconds_left_out = 6'd60 - rem[5:0];
      end
    end else begin
      res.range_error = err1;
      if (!err1) begin
        res.local_seconds = total[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* hdl/epoch_seconds_ordinal_date_convert_core.sv */
// Epoch seconds / ordinal date converter: top level with configuration registers.
// Opcode 0 turns UTC seconds since 1970 plus the zone offset into a packed date
// (year offset * 1000 + day + 1), minutes to midnight and seconds to the minute; opcode 1
// turns a packed date and clock fields back into local seconds. One request is worked at a
// time. Opcode 0 splits local time into days and seconds of day, walks the years since 1970
// with the one-year-per-cycle stepper, then splits the seconds of day into minutes; the day
// split and the clock split each run a quotient step and a remainder step in a
// reciprocal-multiply divider. Opcode 1 runs a divide by 1000 and three multiply/add stages.
// A negative local time or a zero date goes straight to its result. A result waits until
// the output register is free, and sits there while the next request is accepted.
`include "epoch_seconds_ordinal_date_convert_core_defines.svh"

module epoch_seconds_ordinal_date_convert_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  esod_pkg::in_req_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output esod_pkg::out_rsp_t                  out_data,
  input  logic                                cfg_en,
  input  logic [esod_pkg::CfgIdxWidth-1:0]    cfg_index,
  input  logic [esod_pkg::CfgWidth-1:0]       cfg_data
);

  logic signed [16:0] zone_offset;
  logic [9:0]         ticks_per_second;
  esod_pkg::cmd_t     cmd;
  esod_pkg::sts_t     sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset      <= 17'sd46800;
      ticks_per_second <= 10'd60;
    end else if (cfg_en) begin
      unique case (cfg_index)
        esod_pkg::REG_ZONE_OFFSET:      zone_offset      <= $signed(cfg_data);
        esod_pkg::REG_TICKS_PER_SECOND: ticks_per_second <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  esod_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  esod_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .in_data          (in_data),
    .zone_offset      (zone_offset),
    .ticks_per_second (ticks_per_second),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data)
  );

  `ESOD_ASSERT_NEXT(a_busy_after_request, in_valid && in_ready, !in_ready)
  `ESOD_ASSERT_IMPLY(a_error_clears_fields,
      out_valid && out_data.range_error,
      (out_data.local_seconds == 31'd0) && (out_data.packed_date_out == 16'd0))
  `ESOD_ASSERT_IMPLY(a_clock_fields_range,
      out_valid && !out_data.range_error && (out_data.packed_date_out != 16'd0),
      (out_data.minutes_left_out >= 11'd1) && (out_data.minutes_left_out <= 11'd1440) &&
      (out_data.seconds_left_out >= 6'd1) && (out_data.seconds_left_out <= 6'd60))

endmodule

/* tb/epoch_seconds_ordinal_date_convert_core_tb.sv */
// Self-checking testbench for the epoch seconds / ordinal date converter core.
module epoch_seconds_ordinal_date_convert_core_tb;
  import esod_pkg::*;

  localparam longint DAY_SECS   = 86400;
  localparam longint DAY_MINS   = 1440;
  localparam longint MIN_SECS   = 60;
  localparam longint YEAR_DAYS  = 365;
  localparam longint DATE_SCALE = 1000;
  localparam longint MAX_SECS   = 2147483647;
  localparam longint MAX_DATE   = 65535;
  localparam out_rsp_t NO_FIXED = '0;

  typedef struct {
    int       zone;
    int       rate;
    in_req_t  req;
    bit       fixed;
    out_rsp_t want;
  } dir_row_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_req_t                in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_rsp_t               out_data;
  logic                   cfg_en    = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CfgWidth-1:0]    cfg_data  = '0;

  logic signed [16:0] zone_off  = 17'sd46800;
  logic [9:0]         tick_rate = 10'd60;
  out_rsp_t           conversions_due[$];
  dir_row_t           directed_rows[$];
  int                 mismatches = 0;
  bit                 steady     = 1'b0;
  bit                 long_hold  = 1'b0;

  epoch_seconds_ordinal_date_convert_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_rsp_t convert_timestamp(input in_req_t req);
    out_rsp_t r;
    longint   lsec, days, sod, yr, ylen, pdate, total;
    r = '0;
    r.tick_count = tick_rate;
    if (req.opcode == OP_TO_DATE) begin
      lsec = longint'(req.utc_seconds) + longint'(zone_off);
      if (lsec < 0) begin
        r.range_error = 1'b1;
      end else begin
        days = lsec / DAY_SECS;
        sod  = lsec % DAY_SECS;
        yr   = 0;
        ylen = YEAR_DAYS;
        while (days >= ylen) begin
          days -= ylen;
          yr++;
          ylen = (yr % 4 == 2) ? YEAR_DAYS + 1 : YEAR_DAYS;
        end
        pdate = yr * DATE_SCALE + days + 1;
        if (pdate > MAX_DATE) begin
          r.range_error = 1'b1;
        end else begin
          r.packed_date_out  = 16'(pdate);
          r.minutes_left_out = 11'(DAY_MINS - sod / MIN_SECS);
          r.seconds_left_out = 6'(MIN_SECS - sod % MIN_SECS);
        end
      end
    end else if (req.packed_date_in == 16'd0) begin
      r.range_error = 1'b1;
    end else begin
      pdate = longint'(req.packed_date_in) - 1;
      yr    = pdate / DATE_SCALE;
      days  = pdate % DATE_SCALE + yr * YEAR_DAYS + ((yr + 1) >>> 2);
      total = days * DAY_SECS + (DAY_MINS - longint'(req.minutes_left_in)) * MIN_SECS
            + (MIN_SECS - longint'(req.seconds_left_in));
      if (total < 0 || total > MAX_SECS) r.range_error = 1'b1;
      else r.local_seconds = 31'(total);
    end
    return r;
  endfunction

  function automatic in_req_t random_req();
    in_req_t q;
    int      mode, yr, day, jitter, i;
    longint  lsec;
    q.opcode          = 1'($urandom_range(0, 1));
    q.utc_seconds     = 31'($urandom);
    q.packed_date_in  = 16'($urandom);
    q.minutes_left_in = 11'($urandom);
    q.seconds_left_in = 6'($urandom);
    mode = $urandom_range(0, 9);
    if (q.opcode == OP_TO_DATE) begin
      if (mode >= 6) begin
        // land near a local year boundary
        yr     = $urandom_range(0, 68);
        jitter = $urandom_range(0, 400) - 200;
        lsec   = 0;
        for (i = 0; i < yr; i++) lsec += (i % 4 == 2) ? YEAR_DAYS + 1 : YEAR_DAYS;
        lsec = lsec * DAY_SECS + jitter - longint'(zone_off);
        if (lsec < 0) lsec = 0;
        if (lsec > MAX_SECS) lsec = MAX_SECS;
        q.utc_seconds = 31'(lsec);
      end else if (mode == 0) begin
        q.utc_seconds = 31'($urandom_range(0, 100000));
      end else if (mode <= 2) begin
        q.utc_seconds = 31'h7FFF_FFFF - 31'($urandom_range(0, 70000000));
      end
    end else begin
      if (mode >= 4) begin
        yr  = $urandom_range(0, 65);
        day = $urandom_range(1, (yr % 4 == 2) ? 366 : 365);
        q.packed_date_in  = 16'(yr * 1000 + day);
        q.minutes_left_in = 11'($urandom_range(1, 1440));
        q.seconds_left_in = 6'($urandom_range(1, 60));
      end else if (mode == 0) begin
        q.packed_date_in = 16'd0;
      end else if (mode == 1) begin
        q.packed_date_in  = 16'($urandom_range(1, 3));
        q.minutes_left_in = 11'($urandom_range(1400, 2047));
      end
    end
    return q;
  endfunction

  task automatic check_conversion(input out_rsp_t want, input out_rsp_t got);
    if (got.packed_date_out !== want.packed_date_out) begin
      $error("packed_date_out: expected %0d, got %0d", want.packed_date_out,
             got.packed_date_out);
      mismatches++;
    end
    if (got.minutes_left_out !== want.minutes_left_out) begin
      $error("minutes_left_out: expected %0d, got %0d", want.minutes_left_out,
             got.minutes_left_out);
      mismatches++;
    end
    if (got.seconds_left_out !== want.seconds_left_out) begin
      $error("seconds_left_out: expected %0d, got %0d", want.seconds_left_out,
             got.seconds_left_out);
      mismatches++;
    end
    if (got.tick_count !== want.tick_count) begin
      $error("tick_count: expected %0d, got %0d", want.tick_count, got.tick_count);
      mismatches++;
    end
    if (got.local_seconds !== want.local_seconds) begin
      $error("local_seconds: expected %0d, got %0d", want.local_seconds, got.local_seconds);
      mismatches++;
    end
    if (got.range_error !== want.range_error) begin
      $error("range_error: expected %0d, got %0d", want.range_error, got.range_error);
      mismatches++;
    end
  endtask

  task automatic offer_request(input in_req_t req, input out_rsp_t want);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    conversions_due.push_back(want);
  endtask

  task automatic drain_conversions();
    in_valid <= 1'b0;
    while (conversions_due.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(input int zone, input int rate);
    cfg_en    <= 1'b1;
    cfg_index <= REG_ZONE_OFFSET;
    cfg_data  <= CfgWidth'(zone);
    @(posedge clk);
    cfg_index <= REG_TICKS_PER_SECOND;
    cfg_data  <= CfgWidth'(rate);
    @(posedge clk);
    cfg_en    <= 1'b0;
    zone_off  = 17'(zone);
    tick_rate = 10'(rate);
  endtask

  task automatic run_phase(input int zone, input int rate, input int cnt, input bit quiet,
                           input bit hold);
    in_req_t q;
    int      n;
    drain_conversions();
    program_regs(zone, rate);
    steady    = quiet;
    long_hold = hold;
    for (n = 0; n < cnt; n++) begin
      q = random_req();
      offer_request(q, convert_timestamp(q));
      // let the block go empty once mid-phase
      if (n == cnt / 2 && !quiet) drain_conversions();
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (conversions_due.size() == 0) begin
        $error("result with no request outstanding: %h", out_data);
        mismatches++;
      end else begin
        check_conversion(conversions_due.pop_front(), out_data);
      end
    end
  end

  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("epoch_seconds_ordinal_date_convert_core verification failed");
    $finish;
  end

  initial begin
    directed_rows.push_back('{46800, 60, '{OP_TO_DATE, 31'd0, 16'd0, 11'd0, 6'd0},
                              1'b1, '{16'd1, 11'd660, 6'd60, 10'd60, 31'd0, 1'b0}});
    directed_rows.push_back('{46800, 60,
                              '{OP_TO_DATE, 31'h7FFF_FFFF, 16'hFFFF, 11'h7FF, 6'h3F},
                              1'b1, '{16'd0, 11'd0, 6'd0, 10'd60, 31'd0, 1'b1}});
    directed_rows.push_back('{46800, 60, '{OP_TO_DATE, 31'd39599, 16'd0, 11'd0, 6'd0},
                              1'b1, '{16'd1, 11'd1, 6'd1, 10'd60, 31'd0, 1'b0}});
    directed_rows.push_back('{46800, 60, '{OP_TO_DATE, 31'd2082711600, 16'd0, 11'd0, 6'd0},
                              1'b1, '{16'd0, 11'd0, 6'd0, 10'd60, 31'd0, 1'b1}});
    directed_rows.push_back('{46800, 60, '{OP_TO_DATE, 31'd2082711599, 16'd5, 11'd9, 6'd3},
                              1'b0, NO_FIXED});
    directed_rows.push_back('{46800, 60, '{OP_TO_DATE, 31'd94647599, 16'd0, 11'd0, 6'd0},
                              1'b0, NO_FIXED});
    directed_rows.push_back('{46800, 60, '{OP_TO_DATE, 31'd94647600, 16'd0, 11'd0, 6'd0},
                              1'b0, NO_FIXED});
    directed_rows.push_back('{46800, 60,
                              '{OP_TO_SECONDS, 31'h7FFF_FFFF, 16'd0, 11'h7FF, 6'h3F},
                              1'b1, '{16'd0, 11'd0, 6'd0, 10'd60, 31'd0, 1'b1}});
    directed_rows.push_back('{46800, 60, '{OP_TO_SECONDS, 31'd0, 16'd1, 11'd1440, 6'd60},
                              1'b1, '{16'd0, 11'd0, 6'd0, 10'd60, 31'd0, 1'b0}});
    directed_rows.push_back('{46800, 60, '{OP_TO_SECONDS, 31'd0, 16'd1, 11'd1, 6'd1},
                              1'b1, '{16'd0, 11'd0, 6'd0, 10'd60, 31'd86399, 1'b0}});
    directed_rows.push_back('{46800, 60, '{OP_TO_SECONDS, 31'd0, 16'd1, 11'h7FF, 6'h3F},
                              1'b1, '{16'd0, 11'd0, 6'd0, 10'd60, 31'd0, 1'b1}});
    directed_rows.push_back('{46800, 60, '{OP_TO_SECONDS, 31'd0, 16'd1, 11'd0, 6'd0},
                              1'b0, NO_FIXED});
    directed_rows.push_back('{46800, 60, '{OP_TO_SECONDS, 31'd0, 16'hFFFF, 11'd1440, 6'd60},
                              1'b0, NO_FIXED});
    directed_rows.push_back('{46800, 60, '{OP_TO_SECONDS, 31'd0, 16'd2366, 11'd720, 6'd30},
                              1'b0, NO_FIXED});
    directed_rows.push_back('{46800, 60, '{OP_TO_SECONDS, 31'd0, 16'd1999, 11'd600, 6'd10},
                              1'b0, NO_FIXED});
    directed_rows.push_back('{-50400, 0, '{OP_TO_DATE, 31'd0, 16'd0, 11'd0, 6'd0},
                              1'b1, '{16'd0, 11'd0, 6'd0, 10'd0, 31'd0, 1'b1}});
    directed_rows.push_back('{-50400, 0, '{OP_TO_DATE, 31'd50399, 16'd0, 11'd0, 6'd0},
                              1'b1, '{16'd0, 11'd0, 6'd0, 10'd0, 31'd0, 1'b1}});
    directed_rows.push_back('{-50400, 0, '{OP_TO_DATE, 31'd50400, 16'd0, 11'd0, 6'd0},
                              1'b1, '{16'd1, 11'd1440, 6'd60, 10'd0, 31'd0, 1'b0}});
    directed_rows.push_back('{-50400, 0, '{OP_TO_SECONDS, 31'd0, 16'd1001, 11'd1440, 6'd60},
                              1'b0, NO_FIXED});
    directed_rows.push_back('{50400, 1000, '{OP_TO_DATE, 31'd0, 16'd0, 11'd0, 6'd0},
                              1'b1, '{16'd1, 11'd600, 6'd60, 10'd1000, 31'd0, 1'b0}});
    directed_rows.push_back('{50400, 1000, '{OP_TO_DATE, 31'h7FFF_FFFF, 16'd0, 11'd0, 6'd0},
                              1'b1, '{16'd0, 11'd0, 6'd0, 10'd1000, 31'd0, 1'b1}});
    directed_rows.push_back('{50400, 1000, '{OP_TO_SECONDS, 31'd0, 16'hFFFF, 11'd0, 6'd0},
                              1'b0, NO_FIXED});
    directed_rows.push_back('{-1, 1, '{OP_TO_DATE, 31'd0, 16'd0, 11'd0, 6'd0},
                              1'b1, '{16'd0, 11'd0, 6'd0, 10'd1, 31'd0, 1'b1}});
    directed_rows.push_back('{-1, 1, '{OP_TO_DATE, 31'd1, 16'd0, 11'd0, 6'd0},
                              1'b1, '{16'd1, 11'd1440, 6'd60, 10'd1, 31'd0, 1'b0}});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      if (17'(directed_rows[k].zone) != zone_off || 10'(directed_rows[k].rate) != tick_rate)
      begin
        drain_conversions();
        program_regs(directed_rows[k].zone, directed_rows[k].rate);
      end
      offer_request(directed_rows[k].req,
                    directed_rows[k].fixed ? directed_rows[k].want
                                           : convert_timestamp(directed_rows[k].req));
    end

    run_phase(46800, 60, 120, 1'b0, 1'b0);
    run_phase(-50400, 1, 100, 1'b0, 1'b1);
    run_phase(50400, 1000, 100, 1'b1, 1'b0);
    run_phase(0, 0, 80, 1'b0, 1'b0);
    repeat (3) run_phase(int'($urandom_range(0, 100800)) - 50400, $urandom_range(1, 1000),
                         80, 1'b0, 1'b0);

    drain_conversions();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("epoch_seconds_ordinal_date_convert_core verification clean");
    end else begin
      $display("epoch_seconds_ordinal_date_convert_core verification failed");
    end
    $finish;
  end

endmodule
